// File: hw/rtl/rtcm3fr_pkg.sv
// Types, constants and the CRC-24Q byte update shared by the RTCM 3 frame receiver.
package rtcm3fr_pkg;

   localparam logic [7:0]  PREAMBLE_BYTE = 8'hD3;
   localparam logic [23:0] CRC_POLY_LOW  = 24'h864CFB;  // 0x1864CFB without bit 24
   localparam logic [1:0]  LEN_HI_MASK   = 2'b11;

   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Receiver phases, one-hot.
   typedef enum logic [6:0] {
      PH_HUNT    = 7'b000_0001,
      PH_LEN_HI  = 7'b000_0010,
      PH_LEN_LO  = 7'b000_0100,
      PH_PAYLOAD = 7'b000_1000,
      PH_CRC0    = 7'b001_0000,
      PH_CRC1    = 7'b010_0000,
      PH_CRC2    = 7'b100_0000
   } phase_type;

   // One byte of CRC-24Q, MSB first, unrolled into eight shift and xor steps.
   function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
      logic [23:0] c;
      logic        top;
      c = crc ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
         top = c[23];
         c   = {c[22:0], 1'b0} ^ (top ? CRC_POLY_LOW : 24'h000000);
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/rtcm3fr_if.sv
// Valid/ready channel interfaces for the received byte stream and the result words.
interface rtcm3fr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface rtcm3fr_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [9:0] byte_index;
   logic       crc_ok;
   logic [11:0] rtcm_type;
   logic [9:0] frame_payload_len;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output crc_ok, output rtcm_type, output frame_payload_len, input ready);
   modport sink (input valid, input kind, input data_byte, input byte_index,
                 input crc_ok, input rtcm_type, input frame_payload_len, output ready);
endinterface

// File: hw/rtl/rtcm3_frame_receiver.sv
// RTCM 3 transport frame receiver: preamble hunt, header, payload pass-through, CRC-24Q check.
// Result words are registered and appear on rsp in the cycle after their byte is accepted.
// Throughput: one byte per cycle; the frame state and one-byte CRC update are combinational
// and registered on accept. A byte is taken while the result register is empty or draining,
// so a result word held back by the sink stalls the input until it is taken.
// Reset (synchronous, active high) clears the frame state and empties the result register.
module rtcm3_frame_receiver
   import rtcm3fr_pkg::*;
(
   input logic          clock,
   input logic          reset,
   rtcm3fr_req_if.sink   req_ch,
   rtcm3fr_rsp_if.source rsp_ch
);

   // Frame state. The phase walks hunt, two header bytes, the payload, then the
   // three CRC bytes, and returns to hunting after the frame end word.
   phase_type   phase_ff, phase_in;
   logic [9:0]  length_ff, length_in;
   logic [9:0]  count_ff, count_in;
   logic [23:0] crc_ff, crc_in;
   logic [15:0] crc_rx_hi_ff, crc_rx_hi_in;
   logic [11:0] type_ff, type_in;

   // Result register. Its valid bit is control state; the payload needs no reset.
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic [9:0]  out_index_ff, out_index_in;
   logic        out_crc_ok_ff, out_crc_ok_in;
   logic [11:0] out_type_ff, out_type_in;
   logic [9:0]  out_len_ff, out_len_in;

   logic        accept;
   logic        res_valid;
   logic [7:0]  b;
   logic [9:0]  count_plus;
   logic [23:0] crc_next;

   // A new byte is taken whenever the result register is empty or is being drained.
   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.in_byte;
   assign count_plus   = count_ff + 10'd1;
   assign crc_next     = crc_feed(crc_ff, b);

   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      crc_rx_hi_in = crc_rx_hi_ff;
      type_in      = type_ff;

      res_valid    = 1'b0;
      out_kind_in  = KIND_PAYLOAD;
      out_data_in  = 8'h00;
      out_index_in = 10'd0;
      out_crc_ok_in = 1'b0;
      out_type_in  = 12'h000;
      out_len_in   = 10'd0;

      if (accept) begin
         unique case (phase_ff)
            PH_LEN_HI: begin
               // Only the two low bits carry length; the reserved bits still go into the CRC.
               length_in = {b[1:0] & LEN_HI_MASK, 8'h00};
               crc_in    = crc_next;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = {length_ff[9:8], b};
               crc_in    = crc_next;
               count_in  = 10'd0;
               type_in   = 12'h000;
               // An empty payload goes straight to the CRC bytes.
               phase_in  = ({length_ff[9:8], b} == 10'd0) ? PH_CRC0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               crc_in = crc_next;
               // The message type is the first twelve payload bits.
               if (count_ff == 10'd0) begin
                  type_in = {b, 4'h0};
               end else if (count_ff == 10'd1) begin
                  type_in = {type_ff[11:4], b[7:4]};
               end
               res_valid    = 1'b1;
               out_kind_in  = KIND_PAYLOAD;
               out_data_in  = b;
               out_index_in = count_ff;
               count_in     = count_plus;
               if (count_plus >= length_ff) begin
                  phase_in = PH_CRC0;
               end
            end
            PH_CRC0: begin
               crc_rx_hi_in = {b, 8'h00};
               phase_in     = PH_CRC1;
            end
            PH_CRC1: begin
               crc_rx_hi_in = {crc_rx_hi_ff[15:8], b};
               phase_in     = PH_CRC2;
            end
            PH_CRC2: begin
               // Last CRC byte: compare and report, then hunt again whatever the outcome.
               res_valid     = 1'b1;
               out_kind_in   = KIND_FRAME_END;
               out_crc_ok_in = ({crc_rx_hi_ff, b} == crc_ff);
               out_type_in   = (length_ff >= 10'd2) ? type_ff : 12'h000;
               out_len_in    = length_ff;
               phase_in      = PH_HUNT;
            end
            default: begin
               // Hunting, and any phase code that is not a legal state.
               phase_in = PH_HUNT;
               if (b == PREAMBLE_BYTE) begin
                  crc_in       = crc_feed(24'h000000, b);
                  length_in    = 10'd0;
                  count_in     = 10'd0;
                  crc_rx_hi_in = 16'h0000;
                  type_in      = 12'h000;
                  phase_in     = PH_LEN_HI;
               end
            end
         endcase
      end
   end

   // The result register loads on a producing byte and empties when its word is taken.
   always_comb begin
      if (accept && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         length_ff    <= 10'd0;
         count_ff     <= 10'd0;
         crc_ff       <= 24'h000000;
         crc_rx_hi_ff <= 16'h0000;
         type_ff      <= 12'h000;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         crc_rx_hi_ff <= crc_rx_hi_in;
         type_ff      <= type_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         out_kind_ff   <= out_kind_in;
         out_data_ff   <= out_data_in;
         out_index_ff  <= out_index_in;
         out_crc_ok_ff <= out_crc_ok_in;
         out_type_ff   <= out_type_in;
         out_len_ff    <= out_len_in;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.kind              = out_kind_ff;
   assign rsp_ch.data_byte         = out_data_ff;
   assign rsp_ch.byte_index        = out_index_ff;
   assign rsp_ch.crc_ok            = out_crc_ok_ff;
   assign rsp_ch.rtcm_type         = out_type_ff;
   assign rsp_ch.frame_payload_len = out_len_ff;

endmodule
